// ===== design/s5rp_pkg.sv =====
// s5rp_pkg: shared types and constants for the SOCKS5 request parser.
// Holds the parse phase and event codes, protocol byte values and the result word.
// No dependencies.
`default_nettype none

package s5rp_pkg;

  typedef enum logic [3:0] {
    PH_GREET_VER     = 4'd0,
    PH_GREET_NM      = 4'd1,
    PH_GREET_METHODS = 4'd2,
    PH_REQ_VER       = 4'd3,
    PH_REQ_CMD       = 4'd4,
    PH_REQ_RSV       = 4'd5,
    PH_REQ_ATYP      = 4'd6,
    PH_DOMLEN        = 4'd7,
    PH_ADDR          = 4'd8,
    PH_PORT_HI       = 4'd9,
    PH_PORT_LO       = 4'd10,
    PH_PAYLOAD       = 4'd11,
    PH_CLOSED        = 4'd12
  } phase_t;

  typedef enum logic [3:0] {
    EV_CONSUMED   = 4'd0,
    EV_GREET      = 4'd1,
    EV_ADDR       = 4'd2,
    EV_CONNECT    = 4'd3,
    EV_ASSOC      = 4'd4,
    EV_SOCKS4     = 4'd5,
    EV_BAD_ATYP   = 4'd6,
    EV_BAD_CMD    = 4'd7,
    EV_PAYLOAD    = 4'd8,
    EV_NOT_SOCKS5 = 4'd9,
    EV_IGNORED    = 4'd10
  } event_t;

  localparam logic [7:0] VER_SOCKS5  = 8'h05;
  localparam logic [7:0] VER_SOCKS4  = 8'h04;
  localparam logic [7:0] ATYP_IPV4   = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN = 8'h03;
  localparam logic [7:0] ATYP_IPV6   = 8'h04;
  localparam logic [7:0] CMD_CONNECT = 8'h01;
  localparam logic [7:0] CMD_ASSOC   = 8'h03;

  localparam logic [1:0] KIND_IPV4   = 2'd0;
  localparam logic [1:0] KIND_DOMAIN = 2'd1;
  localparam logic [1:0] KIND_IPV6   = 2'd2;

  localparam logic [8:0] LEN_IPV4 = 9'd4;
  localparam logic [8:0] LEN_IPV6 = 9'd16;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  data;
    logic [1:0]  kind;
    logic [15:0] port;
  } result_t;

endpackage

`default_nettype wire

// ===== design/s5rp_front.sv =====
// s5rp_front: byte parser; classifies each accepted byte and pushes one result word.
// Depends on s5rp_pkg.
`default_nettype none

module s5rp_front
  import s5rp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic [7:0] byte_in,
  input  wire logic       session_start,
  input  wire logic       full,
  output logic            push,
  output result_t         push_data
);

  phase_t      phase, phase_next, cur_phase;
  logic [8:0]  field_index, field_index_next, cur_index, index_inc, addr_len;
  logic [7:0]  methods_left, methods_left_next, cur_methods, methods_dec;
  logic [7:0]  command_code, command_code_next, cur_command;
  logic [1:0]  addr_kind, addr_kind_next, cur_kind;
  logic [7:0]  domain_length, domain_length_next, cur_domain;
  logic [15:0] port_accum, port_accum_next, cur_port;
  event_t      ev;
  logic [7:0]  bout;
  logic [15:0] port_out;
  logic        accept;

  assign accept    = req_valid & ~full;
  assign req_stall = full;

  // a session start sees the parser as just reset
  assign cur_phase   = session_start ? PH_GREET_VER : phase;
  assign cur_index   = session_start ? 9'd0 : field_index;
  assign cur_methods = session_start ? 8'd0 : methods_left;
  assign cur_command = session_start ? 8'd0 : command_code;
  assign cur_kind    = session_start ? KIND_IPV4 : addr_kind;
  assign cur_domain  = session_start ? 8'd0 : domain_length;
  assign cur_port    = session_start ? 16'd0 : port_accum;

  assign index_inc   = cur_index + 9'd1;
  assign methods_dec = cur_methods - 8'd1;
  assign addr_len    = (cur_kind == KIND_IPV4) ? LEN_IPV4 :
                       (cur_kind == KIND_IPV6) ? LEN_IPV6 : {1'b0, cur_domain};

  always_comb begin
    case (cur_phase)
      PH_GREET_VER: begin
        phase_next = (byte_in == VER_SOCKS5) ? PH_GREET_NM : PH_CLOSED;
      end
      PH_GREET_NM: begin
        phase_next = (byte_in == 8'd0) ? PH_REQ_VER : PH_GREET_METHODS;
      end
      PH_GREET_METHODS: begin
        phase_next = (methods_dec == 8'd0) ? PH_REQ_VER : PH_GREET_METHODS;
      end
      PH_REQ_VER: begin
        phase_next = (byte_in == VER_SOCKS5) ? PH_REQ_CMD : PH_CLOSED;
      end
      PH_REQ_CMD:  phase_next = PH_REQ_RSV;
      PH_REQ_RSV:  phase_next = PH_REQ_ATYP;
      PH_REQ_ATYP: begin
        if (byte_in == ATYP_IPV4 || byte_in == ATYP_IPV6) phase_next = PH_ADDR;
        else if (byte_in == ATYP_DOMAIN) phase_next = PH_DOMLEN;
        else phase_next = PH_CLOSED;
      end
      PH_DOMLEN: begin
        phase_next = (byte_in == 8'd0) ? PH_PORT_HI : PH_ADDR;
      end
      PH_ADDR: begin
        phase_next = (index_inc >= addr_len) ? PH_PORT_HI : PH_ADDR;
      end
      PH_PORT_HI: phase_next = PH_PORT_LO;
      PH_PORT_LO: begin
        phase_next = (cur_command == CMD_CONNECT) ? PH_PAYLOAD : PH_CLOSED;
      end
      PH_PAYLOAD: phase_next = PH_PAYLOAD;
      default:    phase_next = PH_CLOSED;
    endcase
  end

  always_comb begin
    ev                 = EV_CONSUMED;
    bout               = 8'd0;
    port_out           = 16'd0;
    field_index_next   = cur_index;
    methods_left_next  = cur_methods;
    command_code_next  = cur_command;
    addr_kind_next     = cur_kind;
    domain_length_next = cur_domain;
    port_accum_next    = cur_port;
    case (cur_phase)
      PH_GREET_VER, PH_REQ_VER: begin
        if (byte_in == VER_SOCKS5) ev = EV_CONSUMED;
        else if (byte_in == VER_SOCKS4) ev = EV_SOCKS4;
        else ev = EV_NOT_SOCKS5;
      end
      PH_GREET_NM: begin
        methods_left_next = byte_in;
        if (byte_in == 8'd0) ev = EV_GREET;
      end
      PH_GREET_METHODS: begin
        methods_left_next = methods_dec;
        if (methods_dec == 8'd0) ev = EV_GREET;
      end
      PH_REQ_CMD: command_code_next = byte_in;
      PH_REQ_RSV: ev = EV_CONSUMED;
      PH_REQ_ATYP: begin
        field_index_next = 9'd0;
        if (byte_in == ATYP_IPV4) addr_kind_next = KIND_IPV4;
        else if (byte_in == ATYP_DOMAIN) addr_kind_next = KIND_DOMAIN;
        else if (byte_in == ATYP_IPV6) addr_kind_next = KIND_IPV6;
        else ev = EV_BAD_ATYP;
      end
      PH_DOMLEN: domain_length_next = byte_in;
      PH_ADDR: begin
        ev               = EV_ADDR;
        bout             = byte_in;
        field_index_next = index_inc;
      end
      PH_PORT_HI: port_accum_next = {byte_in, 8'd0};
      PH_PORT_LO: begin
        port_accum_next = {cur_port[15:8], byte_in};
        if (cur_command == CMD_ASSOC) begin
          ev       = EV_ASSOC;
          port_out = {cur_port[15:8], byte_in};
        end else if (cur_command == CMD_CONNECT) begin
          ev       = EV_CONNECT;
          port_out = {cur_port[15:8], byte_in};
        end else begin
          ev = EV_BAD_CMD;
        end
      end
      PH_PAYLOAD: begin
        ev   = EV_PAYLOAD;
        bout = byte_in;
      end
      default: ev = EV_IGNORED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_GREET_VER;
      field_index   <= 9'd0;
      methods_left  <= 8'd0;
      command_code  <= 8'd0;
      addr_kind     <= KIND_IPV4;
      domain_length <= 8'd0;
      port_accum    <= 16'd0;
    end else if (accept) begin
      phase         <= phase_next;
      field_index   <= field_index_next;
      methods_left  <= methods_left_next;
      command_code  <= command_code_next;
      addr_kind     <= addr_kind_next;
      domain_length <= domain_length_next;
      port_accum    <= port_accum_next;
    end
  end

  assign push           = accept;
  assign push_data.ev   = ev;
  assign push_data.data = bout;
  assign push_data.kind = addr_kind_next;
  assign push_data.port = port_out;

endmodule

`default_nettype wire

// ===== design/s5rp_queue.sv =====
// s5rp_queue: small result-word FIFO between the parser and the output stage.
// Depends on s5rp_pkg.
`default_nettype none

module s5rp_queue
  import s5rp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  input  wire logic    pop,
  output logic         not_empty,
  output result_t      pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  result_t       mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full      = (count == FULL_COUNT);
  assign not_empty = (count != '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      if (do_push && !do_pop) count <= count + CW'(1);
      else if (!do_push && do_pop) count <= count - CW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== design/s5rp_back.sv =====
// s5rp_back: output register; drains the FIFO and presents result words downstream.
// Depends on s5rp_pkg.
`default_nettype none

module s5rp_back
  import s5rp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    not_empty,
  input  wire result_t pop_data,
  output logic         pop,
  output logic         res_valid,
  input  wire logic    res_stall,
  output logic [3:0]   event_res,
  output logic [7:0]   byte_out,
  output logic [1:0]   address_kind,
  output logic [15:0]  dest_port
);

  result_t hold;

  assign pop = not_empty & (~res_valid | ~res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hold <= pop_data;
    end
  end

  assign event_res    = hold.ev;
  assign byte_out     = hold.data;
  assign address_kind = hold.kind;
  assign dest_port    = hold.port;

endmodule

`default_nettype wire

// ===== design/socks5_request_parser.sv =====
// socks5_request_parser: SOCKS5 greeting and request parser, one client byte per word.
// Depends on s5rp_pkg, s5rp_front, s5rp_queue, s5rp_back.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_stall    byte_in, session_start
//   res      out  res_valid/res_stall    event_res, byte_out, address_kind, dest_port
//
// One byte per cycle in while req_stall is low, one result word per byte out, set by the parse FSM.
// A byte's result word passes the queue, then the output register, before res_valid rises; res_stall can hold it back.
// Synchronous reset clears the parser, the queue and res_valid; the held result word is not reset.
// req_stall rises only when the QUEUE_DEPTH-word queue is full.
`default_nettype none

module socks5_request_parser
  import s5rp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [7:0]  byte_in,
  input  wire logic        session_start,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [3:0]       event_res,
  output logic [7:0]       byte_out,
  output logic [1:0]       address_kind,
  output logic [15:0]      dest_port
);

  logic    push, full, pop, not_empty;
  result_t push_data, pop_data;

  s5rp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .byte_in       (byte_in),
    .session_start (session_start),
    .full          (full),
    .push          (push),
    .push_data     (push_data)
  );

  s5rp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  s5rp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .not_empty    (not_empty),
    .pop_data     (pop_data),
    .pop          (pop),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .event_res    (event_res),
    .byte_out     (byte_out),
    .address_kind (address_kind),
    .dest_port    (dest_port)
  );

endmodule

`default_nettype wire
